@@ src/sfa_pkg.sv @@
`default_nettype none
package sfa_pkg;

  // one table entry held by a cell
  typedef struct packed {
    logic        valid;
    logic        owned;
    logic [15:0] len;
    logic [15:0] owner;
    logic [31:0] ltime;
  } seg_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_ROT,
    C_INIT,
    C_ALLOC,
    C_FREE,
    C_MERGE
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t    op;
    logic        split;
    seg_t        ent;
    logic [15:0] rest;
    logic [15:0] cap;
  } cell_ctrl_t;

  // per-cell position decode
  typedef struct packed {
    logic sel;
    logic nxt;
    logic shup;
    logic mhead;
    logic mshift;
  } cell_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOD,
    S_MERGE,
    S_PCT,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_EVICT = 2'd2;
  localparam logic [1:0] FN_MERGE = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOEVICT  = 3'd4;

  localparam logic REG_CAP  = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic [15:0] RESET_CAP = 16'd1024;
  localparam logic [6:0]  PCT_MAX   = 7'd100;

endpackage
`default_nettype wire

@@ src/sfa_in_if.sv @@
`default_nettype none
interface sfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] proc_id;
  logic [15:0] proc_size;
  logic [31:0] now;

  modport source (output valid, func, proc_id, proc_size, now, input ready);
  modport sink (input valid, func, proc_id, proc_size, now, output ready);
endinterface
`default_nettype wire

@@ src/sfa_out_if.sv @@
`default_nettype none
interface sfa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] evicted_id;
  logic [6:0]  usage_percent;
  logic [5:0]  hole_count;

  modport source (output valid, status, evicted_id, usage_percent, hole_count, input ready);
  modport sink (input valid, status, evicted_id, usage_percent, hole_count, output ready);
endinterface
`default_nettype wire

@@ src/sfa_cell.sv @@
`default_nettype none
module sfa_cell #(
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sfa_pkg::cell_ctrl_t  ctrl,
  input  sfa_pkg::cell_sel_t   sel,
  input  sfa_pkg::seg_t        up,
  input  sfa_pkg::seg_t        dn,
  output sfa_pkg::seg_t        ent
);

  sfa_pkg::seg_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctrl.op)
      sfa_pkg::C_HOLD: begin
      end
      sfa_pkg::C_ROT: begin
        ent_nxt = up;
      end
      sfa_pkg::C_INIT: begin
        ent_nxt.valid = FIRST;
        ent_nxt.owned = 1'b0;
        ent_nxt.len   = FIRST ? ctrl.cap : 16'd0;
      end
      sfa_pkg::C_ALLOC: begin
        if (sel.sel) begin
          ent_nxt = ctrl.ent;
        end else if (ctrl.split && sel.nxt) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.owned = 1'b0;
          ent_nxt.len   = ctrl.rest;
        end else if (ctrl.split && sel.shup) begin
          ent_nxt = dn;
        end
      end
      sfa_pkg::C_FREE: begin
        if (sel.sel) ent_nxt.owned = 1'b0;
      end
      sfa_pkg::C_MERGE: begin
        if (sel.mhead) begin
          ent_nxt.len = ent_r.len + up.len;
        end else if (sel.mshift) begin
          if (LAST) begin
            ent_nxt.valid = 1'b0;
            ent_nxt.owned = 1'b0;
            ent_nxt.len   = 16'd0;
          end else begin
            ent_nxt = up;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // owner and load time carry no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= FIRST;
      ent_r.owned <= 1'b0;
      ent_r.len   <= FIRST ? sfa_pkg::RESET_CAP : 16'd0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
      ent_r.owned <= ent_nxt.owned;
      ent_r.len   <= ent_nxt.len;
    end
    ent_r.owner <= ent_nxt.owner;
    ent_r.ltime <= ent_nxt.ltime;
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

@@ src/sfa_div.sv @@
`default_nettype none
module sfa_div (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [15:0] owned,
  input  wire  [15:0] cap,
  output logic        done,
  output logic [6:0]  quo
);

  localparam logic [2:0] LAST_STEP = 3'd6;

  logic        busy_r;
  logic        done_r;
  logic [2:0]  cnt_r;
  logic [22:0] rem_r;
  logic [22:0] dvs_r;
  logic [6:0]  quo_r;
  logic        ge;

  assign ge = (rem_r >= dvs_r);

  // restoring division, one quotient bit a cycle, msb first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= ({7'd0, owned} * 23'd100) + {7'd0, cap} - 23'd1;
      dvs_r <= {1'b0, cap, 6'd0};
      quo_r <= 7'd0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dvs_r;
      dvs_r <= {1'b0, dvs_r[22:1]};
      quo_r <= {quo_r[5:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

@@ src/segment_fit_allocator_core.sv @@
// flow: alloc, free and evict make one full rotation of the cell ring from accept,
//   then update the table and divide
// merge joins adjacent holes one pair at a time until none are left, then divides
// throughput: one word in flight; the next word is taken while the result waits
// reset: table is one hole of 1024 units, first fit, no result pending
`default_nettype none
module segment_fit_allocator_core #(
  parameter int MAX_SEGMENTS = 32
) (
  input  wire          clk,
  input  wire          rst_n,
  sfa_in_if.sink       in_ch,
  sfa_out_if.source    out_ch,
  input  wire          cfg_we,
  input  wire          cfg_idx,
  input  wire  [15:0]  cfg_wdata
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  // ring of cells, cell 0 is the head the controller looks at
  sfa_pkg::seg_t      ent  [MAX_SEGMENTS];
  sfa_pkg::cell_sel_t csel [MAX_SEGMENTS];
  sfa_pkg::cell_ctrl_t ctrl;

  sfa_pkg::state_t state_r, state_nxt;

  // config
  logic [15:0] cap_r;
  logic [1:0]  mode_r;

  // latched word
  logic [1:0]  func_r;
  logic [15:0] id_r;
  logic [15:0] size_r;
  logic [31:0] now_r;

  // scan results
  logic [IW-1:0] k_r;
  logic          found_r;
  logic [IW-1:0] pick_r;
  logic [15:0]   plen_r;
  logic [31:0]   page_r;
  logic [15:0]   powner_r;

  // running table totals
  logic [CW-1:0] total_r;
  logic [CW-1:0] holes_r;
  logic [15:0]   owned_r;

  logic [2:0]  status_r;
  logic [15:0] victim_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_victim_r;
  logic [6:0]  out_pct_r;
  logic [5:0]  out_holes_r;

  logic in_acc;
  logic out_free;
  logic scan_last;
  logic take;
  logic [31:0] age;
  logic [15:0] rest;
  logic split;
  logic full;
  logic alloc_ok;
  logic [MAX_SEGMENTS-1:0] mvec, mlow, mge;
  logic div_start, div_done;
  logic [6:0] div_quo;
  logic [6:0] pct;

  assign in_ch.ready = (state_r == sfa_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign scan_last   = (k_r == IW'(MAX_SEGMENTS - 1));

  // candidate test on the head cell during the scan rotation
  assign age = now_r - ent[0].ltime;
  always_comb begin
    take = 1'b0;
    unique case (func_r)
      sfa_pkg::FN_ALLOC: begin
        if (ent[0].valid && !ent[0].owned && (ent[0].len >= size_r)) begin
          if (!found_r) take = 1'b1;
          else if (mode_r == sfa_pkg::FIT_FIRST) take = 1'b0;
          else if (mode_r == sfa_pkg::FIT_BEST) take = (ent[0].len < plen_r);
          else take = (ent[0].len > plen_r);
        end
      end
      sfa_pkg::FN_FREE: begin
        take = ent[0].valid && ent[0].owned && (ent[0].owner == id_r) && !found_r;
      end
      sfa_pkg::FN_EVICT: begin
        take = ent[0].valid && ent[0].owned && (!found_r || (age > page_r));
      end
      default: take = 1'b0;
    endcase
  end

  // placement decision
  assign rest     = plen_r - size_r;
  assign split    = (rest != 16'd0);
  assign full     = (total_r == CW'(MAX_SEGMENTS));
  assign alloc_ok = found_r && !(split && full);

  // adjacent hole pairs: bit i set when cell i can fold into cell i-1
  assign mvec[0] = 1'b0;
  for (genvar i = 1; i < MAX_SEGMENTS; i++) begin : g_mvec
    assign mvec[i] = ent[i].valid && !ent[i].owned && ent[i-1].valid && !ent[i-1].owned;
  end
  assign mlow = mvec & (~mvec + MAX_SEGMENTS'(1));
  assign mge  = ~(mlow - MAX_SEGMENTS'(1));

  // cells and their position decode
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    sfa_pkg::seg_t dn_ent;
    if (i == 0) begin : g_first
      assign dn_ent = '0;
    end else begin : g_rest
      assign dn_ent = ent[i-1];
    end

    assign csel[i].sel    = (IW'(i) == pick_r);
    assign csel[i].nxt    = (CW'(i) == (CW'(pick_r) + CW'(1)));
    assign csel[i].shup   = (CW'(i) >  (CW'(pick_r) + CW'(1)));
    assign csel[i].mshift = mge[i];
    if (i < MAX_SEGMENTS - 1) begin : g_mh
      assign csel[i].mhead = mlow[i+1];
    end else begin : g_mh_last
      assign csel[i].mhead = 1'b0;
    end

    sfa_cell #(
      .FIRST(i == 0),
      .LAST (i == MAX_SEGMENTS - 1)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctrl (ctrl),
      .sel  (csel[i]),
      .up   (ent[(i + 1) % MAX_SEGMENTS]),
      .dn   (dn_ent),
      .ent  (ent[i])
    );
  end

  // percent unit
  sfa_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .owned(owned_r),
    .cap  (cap_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign div_start = (state_r == sfa_pkg::S_PCT);
  assign pct = (cap_r == 16'd0) ? 7'd0 :
               ((div_quo > sfa_pkg::PCT_MAX) ? sfa_pkg::PCT_MAX : div_quo);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == sfa_pkg::FN_MERGE) state_nxt = sfa_pkg::S_MERGE;
          else state_nxt = sfa_pkg::S_SCAN;
        end
      end
      sfa_pkg::S_SCAN: begin
        if (scan_last) state_nxt = sfa_pkg::S_MOD;
      end
      sfa_pkg::S_MOD:   state_nxt = sfa_pkg::S_PCT;
      sfa_pkg::S_MERGE: begin
        if (mvec == '0) state_nxt = sfa_pkg::S_PCT;
      end
      sfa_pkg::S_PCT:   state_nxt = sfa_pkg::S_DIV;
      sfa_pkg::S_DIV: begin
        if (div_done) state_nxt = sfa_pkg::S_DONE;
      end
      sfa_pkg::S_DONE: begin
        if (out_free) state_nxt = sfa_pkg::S_IDLE;
      end
      default: state_nxt = sfa_pkg::S_IDLE;
    endcase
  end

  // cell command
  always_comb begin
    ctrl.op        = sfa_pkg::C_HOLD;
    ctrl.split     = split;
    ctrl.rest      = rest;
    ctrl.cap       = cfg_wdata;
    ctrl.ent.valid = 1'b1;
    ctrl.ent.owned = 1'b1;
    ctrl.ent.len   = size_r;
    ctrl.ent.owner = id_r;
    ctrl.ent.ltime = now_r;
    if (cfg_we && (cfg_idx == sfa_pkg::REG_CAP)) begin
      ctrl.op = sfa_pkg::C_INIT;
    end else begin
      unique case (state_r)
        sfa_pkg::S_SCAN: ctrl.op = sfa_pkg::C_ROT;
        sfa_pkg::S_MOD: begin
          if (func_r == sfa_pkg::FN_ALLOC) begin
            if (alloc_ok) ctrl.op = sfa_pkg::C_ALLOC;
          end else if (found_r) begin
            ctrl.op = sfa_pkg::C_FREE;
          end
        end
        sfa_pkg::S_MERGE: begin
          if (mvec != '0) ctrl.op = sfa_pkg::C_MERGE;
        end
        default: ctrl.op = sfa_pkg::C_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sfa_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // config and table totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= sfa_pkg::RESET_CAP;
      mode_r  <= sfa_pkg::FIT_FIRST;
      total_r <= CW'(1);
      holes_r <= CW'(1);
      owned_r <= 16'd0;
    end else if (cfg_we) begin
      if (cfg_idx == sfa_pkg::REG_CAP) begin
        cap_r   <= cfg_wdata;
        total_r <= CW'(1);
        holes_r <= CW'(1);
        owned_r <= 16'd0;
      end else begin
        mode_r <= cfg_wdata[1:0];
      end
    end else if (state_r == sfa_pkg::S_MOD) begin
      if (func_r == sfa_pkg::FN_ALLOC) begin
        if (alloc_ok) begin
          owned_r <= owned_r + size_r;
          if (split) total_r <= total_r + CW'(1);
          else       holes_r <= holes_r - CW'(1);
        end
      end else if (found_r) begin
        owned_r <= owned_r - plen_r;
        holes_r <= holes_r + CW'(1);
      end
    end else if ((state_r == sfa_pkg::S_MERGE) && (mvec != '0)) begin
      total_r <= total_r - CW'(1);
      holes_r <= holes_r - CW'(1);
    end
  end

  // word, scan and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      found_r <= 1'b0;
    end else if (in_acc) begin
      k_r     <= '0;
      found_r <= 1'b0;
    end else if (state_r == sfa_pkg::S_SCAN) begin
      k_r <= k_r + IW'(1);
      if (take) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_ch.func;
      id_r     <= in_ch.proc_id;
      size_r   <= in_ch.proc_size;
      now_r    <= in_ch.now;
      status_r <= sfa_pkg::ST_OK;
      victim_r <= 16'd0;
    end else if (state_r == sfa_pkg::S_SCAN) begin
      if (take) begin
        pick_r   <= k_r;
        plen_r   <= ent[0].len;
        page_r   <= age;
        powner_r <= ent[0].owner;
      end
    end else if (state_r == sfa_pkg::S_MOD) begin
      unique case (func_r)
        sfa_pkg::FN_ALLOC: begin
          if (!found_r)   status_r <= sfa_pkg::ST_NOFIT;
          else if (!alloc_ok) status_r <= sfa_pkg::ST_FULL;
        end
        sfa_pkg::FN_FREE: begin
          if (!found_r) status_r <= sfa_pkg::ST_NOTFOUND;
        end
        sfa_pkg::FN_EVICT: begin
          if (!found_r) status_r <= sfa_pkg::ST_NOEVICT;
          else          victim_r <= powner_r;
        end
        default: begin
        end
      endcase
    end
  end

  // result register, parts the output from the engine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == sfa_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == sfa_pkg::S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_victim_r <= victim_r;
      out_pct_r    <= pct;
      out_holes_r  <= 6'(holes_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.evicted_id    = out_victim_r;
  assign out_ch.usage_percent = out_pct_r;
  assign out_ch.hole_count    = out_holes_r;

  // table never empty and never past the ring size
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r >= CW'(1)) && (total_r <= CW'(MAX_SEGMENTS)))
    else $error("entry count out of range");

  // holes are a subset of the entries
  a_holes_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    holes_r <= total_r)
    else $error("hole count above entry count");

  // owned units stay within capacity
  a_owned_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    owned_r <= cap_r)
    else $error("owned units above capacity");

  // one word at a time through the engine
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted while busy");

endmodule
`default_nettype wire
